/* src/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// ante implies cons at the same edge.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// ante implies cons at the next edge.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/brf_pkg.sv */
`default_nettype none

package brf_pkg;

  // level, pointer and length width (capacity is at most 511 * 4 bytes)
  localparam int CW = 11;
  localparam int QW = 9;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_PEEK   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NOT_ENOUGH = 2'd2,
    ST_BAD_LEN   = 2'd3
  } status_e;

endpackage

`default_nettype wire

/* src/brf_ram.sv */
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds while no read is issued
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* src/byte_ring_fifo_peek_discard.sv */
`default_nettype none

// Circular byte FIFO with peek and discard. Bytes live in one DEPTH x 8
// synchronous RAM (one write and one read port, registered read). The ring
// size in use is 4 * capacity_quads bytes (0 acts as 1, clamped to DEPTH);
// writing the register empties the ring. Requests come in on the slave
// stream (tuser = request kind) and are not queued for room or data: a request that cannot be
// served gets one refusal result. The read pointer and the fill level are
// committed in the cycle a request is accepted, so every result shows the
// level after that request; the write pointer steps once per stored byte.
// A refused, zero-length or remove request is answered straight from the
// idle state; a write stores one byte per cycle in the write state (one RAM
// write per byte), then gives its result; a read or peek issues the first
// RAM read, then gives one byte per cycle while the sink is ready. A new
// request is taken once the sequencer is idle and the output register is
// empty or being emptied in that cycle. The RAM is never cleared; only
// written bytes are ever read.
module byte_ring_fifo_peek_discard
  import brf_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_WRITE = 8,
  parameter int MAX_READ  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // capacity_quads
  input  wire logic                  cfg_we_i,
  input  wire logic [QW-1:0]         cfg_wdata_i,
  // tdata: write_bytes[63:0], run_length[74:64], zero pad[79:75]
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: req_type[1:0]
  input  wire logic [1:0]            s_axis_tuser,
  // tdata: read_byte[7:0], amount_done[18:8], fill_level[29:19],
  //        buffer_empty[30], buffer_full[31]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int AW      = $clog2(DEPTH);
  localparam int LEN_MAX = (MAX_READ > MAX_WRITE) ? MAX_READ : MAX_WRITE;
  localparam int NW      = $clog2(LEN_MAX + 1);
  localparam int CAP_RST = (DEPTH < 1024) ? DEPTH : 1024;

  // sequencer states
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WRITE = 2'd1;
  localparam logic [1:0] S_RDISS = 2'd2;
  localparam logic [1:0] S_RDDAT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] cap_q, cap_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] rp_q, rp_d;
  logic [CW-1:0] wp_q, wp_d;
  logic [CW-1:0] cur_q, cur_d;   // read cursor of a run
  logic [NW-1:0] cnt_q, cnt_d;   // bytes left to write or to fetch
  logic [CW-1:0] amt_q, amt_d;
  logic [63:0]   wbuf_q, wbuf_d;

  logic          out_valid_q, out_valid_d;
  logic [1:0]    out_status_q, out_status_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic [CW-1:0] out_amt_q, out_amt_d;

  // RAM side
  logic          ram_we, ram_re;
  logic [CW-1:0] ram_wptr, ram_rptr;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [AW+CW-1:0] waddr_ext, raddr_ext;
  logic [7:0]    ram_rdata;

  // request fields
  logic [1:0]    req_type;
  logic [63:0]   req_bytes;
  logic [CW-1:0] req_len;

  logic          in_xfer, out_free;
  logic [CW-1:0] free_space, rm_cnt, cur_inc, wp_inc;
  logic [CW:0]   rp_sum, rp_wrap;
  logic [QW-1:0] cfg_q0;
  logic [CW-1:0] cfg_cap4;

  assign req_type  = s_axis_tuser;
  assign req_bytes = s_axis_tdata[63:0];
  assign req_len   = s_axis_tdata[64 +: CW];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign free_space = cap_q - fill_q;
  assign rm_cnt     = (req_len < fill_q) ? req_len : fill_q;

  // pointer advance with a single wrap compare
  assign cur_inc = (cur_q + CW'(1) == cap_q) ? '0 : cur_q + CW'(1);
  assign wp_inc  = (wp_q + CW'(1) == cap_q) ? '0 : wp_q + CW'(1);

  // capacity from the register value
  assign cfg_q0   = (cfg_wdata_i == '0) ? QW'(1) : cfg_wdata_i;
  assign cfg_cap4 = {cfg_q0, 2'b00};

  always_comb begin
    state_d      = state_q;
    cap_d        = cap_q;
    fill_d       = fill_q;
    rp_d         = rp_q;
    wp_d         = wp_q;
    cur_d        = cur_q;
    cnt_d        = cnt_q;
    amt_d        = amt_q;
    wbuf_d       = wbuf_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_amt_d    = out_amt_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_wptr     = wp_q;
    ram_rptr     = cur_q;
    rp_sum       = '0;
    rp_wrap      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          // default: one final result, nothing done
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_byte_d   = '0;
          out_last_d   = 1'b1;
          out_amt_d    = '0;
          case (req_type)
            REQ_WRITE: begin
              if (32'(req_len) > MAX_WRITE) begin
                out_status_d = ST_BAD_LEN;
              end else if (req_len > free_space) begin
                out_status_d = ST_NO_ROOM;
              end else if (req_len != '0) begin
                out_valid_d = 1'b0;
                fill_d      = fill_q + req_len;
                cnt_d       = NW'(req_len);
                amt_d       = req_len;
                wbuf_d      = req_bytes;
                state_d     = S_WRITE;
              end
            end
            REQ_REMOVE: begin
              rp_sum  = {1'b0, rp_q} + {1'b0, rm_cnt};
              rp_wrap = rp_sum - {1'b0, cap_q};
              rp_d    = (rp_sum >= {1'b0, cap_q}) ? rp_wrap[CW-1:0] : rp_sum[CW-1:0];
              fill_d  = fill_q - rm_cnt;
              out_amt_d = rm_cnt;
            end
            default: begin
              // read or peek
              if (32'(req_len) > MAX_READ) begin
                out_status_d = ST_BAD_LEN;
              end else if (req_len > fill_q) begin
                out_status_d = ST_NOT_ENOUGH;
              end else if (req_len != '0) begin
                out_valid_d = 1'b0;
                cur_d       = rp_q;
                cnt_d       = NW'(req_len);
                amt_d       = req_len;
                state_d     = S_RDISS;
                if (req_type == REQ_READ) begin
                  rp_sum  = {1'b0, rp_q} + {1'b0, req_len};
                  rp_wrap = rp_sum - {1'b0, cap_q};
                  rp_d    = (rp_sum >= {1'b0, cap_q}) ? rp_wrap[CW-1:0]
                                                      : rp_sum[CW-1:0];
                  fill_d  = fill_q - req_len;
                end
              end
            end
          endcase
        end
      end

      S_WRITE: begin
        ram_we = 1'b1;
        wp_d   = wp_inc;
        wbuf_d = {8'h00, wbuf_q[63:8]};
        cnt_d  = cnt_q - NW'(1);
        if (cnt_q == NW'(1)) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_byte_d   = '0;
          out_last_d   = 1'b1;
          out_amt_d    = amt_q;
          state_d      = S_IDLE;
        end
      end

      S_RDISS: begin
        ram_re  = 1'b1;
        cur_d   = cur_inc;
        cnt_d   = cnt_q - NW'(1);
        state_d = S_RDDAT;
      end

      default: begin
        // S_RDDAT: RAM data is valid and holds until taken
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_byte_d   = ram_rdata;
          out_last_d   = (cnt_q == '0);
          out_amt_d    = amt_q;
          if (cnt_q == '0) begin
            state_d = S_IDLE;
          end else begin
            ram_re = 1'b1;
            cur_d  = cur_inc;
            cnt_d  = cnt_q - NW'(1);
          end
        end
      end
    endcase

    // capacity write empties the ring (the user writes it only while idle; the block does not enforce this)
    if (cfg_we_i) begin
      cap_d  = (32'(cfg_cap4) > DEPTH) ? CW'(DEPTH) : cfg_cap4;
      fill_d = '0;
      rp_d   = '0;
      wp_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CW'(CAP_RST);
      fill_q      <= '0;
      rp_q        <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      fill_q      <= fill_d;
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    amt_q        <= amt_d;
    wbuf_q       <= wbuf_d;
    out_status_q <= out_status_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_amt_q    <= out_amt_d;
  end

  // pointer to RAM address (pointer is always below DEPTH)
  assign waddr_ext = {{AW{1'b0}}, ram_wptr};
  assign raddr_ext = {{AW{1'b0}}, ram_rptr};
  assign ram_waddr = waddr_ext[AW-1:0];
  assign ram_raddr = raddr_ext[AW-1:0];

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wbuf_q[7:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // level flags follow the committed level; it moves only on an accepted
  // request (output register empty or being emptied) or a capacity write
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {fill_q == cap_q, fill_q == '0, fill_q, out_amt_q, out_byte_q};

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_fill_le_cap, clk_i, rst_ni, fill_q <= cap_q, "fill level above capacity")
  `ASSERT_ALWAYS(a_ptr_in_ring, clk_i, rst_ni, (rp_q < cap_q) && (wp_q < cap_q),
    "pointer outside ring")
  `ASSERT_IMPLIES(a_write_no_out, clk_i, rst_ni, state_q == S_WRITE, !out_valid_q,
    "result pending during write")
  `ASSERT_NEXT(a_run_issue, clk_i, rst_ni, state_q == S_RDISS,
    state_q == S_RDDAT && cnt_q == $past(cnt_q) - NW'(1), "read issue did not advance")

endmodule

`default_nettype wire

/* dv/ring_fifo_checker.sv */
`timescale 1ns / 100ps

// Watches both streams and the capacity port, keeps its own copy of the
// ring, and compares every output transfer with the oldest awaited result.
module ring_fifo_checker
  import brf_pkg::*;
#(
  parameter int DEPTH     = 1024,
  parameter int MAX_WRITE = 8,
  parameter int MAX_READ  = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [QW-1:0]         cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  wire logic [1:0]            s_axis_tuser,
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [1:0]            m_axis_tuser,
  input  wire logic                  m_axis_tlast,
  output int                         pending_o,
  output int                         fail_count_o,
  output logic [CW-1:0]              level_o
);

  typedef struct {
    status_e       status;
    logic [7:0]    rd_byte;
    logic          last;
    logic [CW-1:0] amount;
    logic [CW-1:0] fill;
    logic          empty;
    logic          full;
  } fifo_resp_t;

  logic [7:0]  ring_mem [DEPTH];
  int unsigned rd_ptr;
  int unsigned wr_ptr;
  int unsigned free_bytes;
  int unsigned quads;
  int          fails;
  fifo_resp_t  awaited_q [$];

  function automatic int unsigned ring_size();
    int unsigned q;
    int unsigned c;
    q = quads & 'h1FF;
    if (q == 0) q = 1;
    c = q * 4;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic int unsigned fill_now();
    int unsigned cap;
    cap = ring_size();
    return (free_bytes <= cap) ? cap - free_bytes : 0;
  endfunction

  function automatic void clear_ring();
    rd_ptr     = 0;
    wr_ptr     = 0;
    free_bytes = ring_size();
  endfunction

  // status flags reflect the ring after the request
  function automatic void queue_result(status_e st, logic [7:0] b, logic lst,
                                       int unsigned amt);
    fifo_resp_t  r;
    int unsigned fill;
    fill      = fill_now();
    r.status  = st;
    r.rd_byte = b;
    r.last    = lst;
    r.amount  = CW'(amt);
    r.fill    = CW'(fill);
    r.empty   = (fill == 0);
    r.full    = (free_bytes == 0);
    awaited_q.push_back(r);
  endfunction

  function automatic void model_request(req_e kind, logic [63:0] bytes,
                                        int unsigned len);
    int unsigned cap;
    int unsigned fill;
    int unsigned cnt;
    int unsigned p;
    logic [7:0]  got [MAX_READ];
    cap  = ring_size();
    fill = fill_now();
    case (kind)
      REQ_WRITE: begin
        if (len > MAX_WRITE) begin
          queue_result(ST_BAD_LEN, 8'd0, 1'b1, 0);
        end else if (len > free_bytes) begin
          queue_result(ST_NO_ROOM, 8'd0, 1'b1, 0);
        end else begin
          for (int i = 0; i < len; i++) begin
            p           = wr_ptr % cap;
            ring_mem[p] = bytes[8*i +: 8];
            wr_ptr      = (p + 1) % cap;
          end
          free_bytes -= len;
          queue_result(ST_OK, 8'd0, 1'b1, len);
        end
      end
      REQ_REMOVE: begin
        cnt         = (len < fill) ? len : fill;
        rd_ptr      = (rd_ptr % cap + cnt) % cap;
        free_bytes += cnt;
        queue_result(ST_OK, 8'd0, 1'b1, cnt);
      end
      default: begin
        if (len > MAX_READ) begin
          queue_result(ST_BAD_LEN, 8'd0, 1'b1, 0);
        end else if (len > fill) begin
          queue_result(ST_NOT_ENOUGH, 8'd0, 1'b1, 0);
        end else if (len == 0) begin
          queue_result(ST_OK, 8'd0, 1'b1, 0);
        end else begin
          p = rd_ptr % cap;
          for (int i = 0; i < len; i++) begin
            got[i] = ring_mem[p];
            p      = (p + 1) % cap;
          end
          // peek leaves the head alone
          if (kind == REQ_READ) begin
            rd_ptr      = p;
            free_bytes += len;
          end
          for (int i = 0; i < len; i++) begin
            queue_result(ST_OK, got[i], (i + 1 == len), len);
          end
        end
      end
    endcase
  endfunction

  function automatic void check_field(string what, int unsigned want,
                                      int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    fifo_resp_t want;
    if (!rst_ni) begin
      foreach (ring_mem[i]) ring_mem[i] = 8'd0;
      quads = 256;
      clear_ring();
      awaited_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        quads = cfg_wdata_i;
        clear_ring();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        model_request(req_e'(s_axis_tuser), s_axis_tdata[63:0], s_axis_tdata[74:64]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_q.size() == 0) begin
          $display("%0t: unexpected transfer: expected none, actual tdata %h tuser %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("read_byte", want.rd_byte, m_axis_tdata[7:0]);
          check_field("last", want.last, m_axis_tlast);
          check_field("amount_done", want.amount, m_axis_tdata[18:8]);
          check_field("fill_level", want.fill, m_axis_tdata[29:19]);
          check_field("buffer_empty", want.empty, m_axis_tdata[30]);
          check_field("buffer_full", want.full, m_axis_tdata[31]);
        end
      end
    end
    pending_o    <= awaited_q.size();
    fail_count_o <= fails;
    level_o      <= CW'(fill_now());
  end

endmodule

/* dv/byte_ring_fifo_peek_discard_tb.sv */
`timescale 1ns / 100ps

// Top of the ring FIFO bench: clock, reset, request stimulus, sink stalls
// and the verdict. Prediction and comparison live in ring_fifo_checker.
module byte_ring_fifo_peek_discard_tb;
  import brf_pkg::*;

  localparam int LIMIT  = 600000;  // cycles; far above the slowest legal run
  localparam int MAX_RD = 64;
  localparam int DRAIN_WAIT = 12;  // covers the longest write sequence

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} mix_e;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_we_i      = 1'b0;
  logic [QW-1:0]         cfg_wdata_i   = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [1:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  int            pending;
  int            fail_count;
  logic [CW-1:0] level_hint;   // checker's fill level, one transfer stale at most

  int cycles     = 0;
  bit tx_live    = 1'b0;       // tvalid is currently driven high
  int burst_left = 0;
  bit steady     = 1'b0;       // no idling on either side
  int rx_hold    = 0;
  bit rx_on      = 1'b0;

  int phase_caps [8] = '{2, 16, 511, 0, 40, 0, 256, 1};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  byte_ring_fifo_peek_discard dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ring_fifo_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .pending_o     (pending),
    .fail_count_o  (fail_count),
    .level_o       (level_hint)
  );

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("FAIL byte_ring_fifo_peek_discard");
      $finish;
    end
  end

  // Sink: alternating ready and stall runs of random length, or always
  // ready in steady phases.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold--;
    end else if (steady) begin
      rx_on   = 1'b1;
      rx_hold = 4;
    end else begin
      rx_on   = !rx_on;
      rx_hold = rx_on ? $urandom_range(0, 9) : $urandom_range(0, 4);
    end
    m_axis_tready <= rx_on;
  end

  // One request transfer. Called right after a rising edge. Within a burst
  // tvalid stays high into the next call; at the end of a burst it drops
  // for a gap before the next call, so it is never lowered and raised in
  // the same step.
  task automatic send_req(req_e kind, logic [63:0] bytes, int unsigned len);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {5'b0, CW'(len), bytes};
    tx_live = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (steady) begin
        burst_left = 64;
      end else begin
        s_axis_tvalid <= 1'b0;
        tx_live = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
    end
  endtask

  // Stop sending and wait until every awaited result has come back, plus
  // enough cycles for a trailing RAM write sequence to finish.
  task automatic settle();
    if (tx_live) begin
      s_axis_tvalid <= 1'b0;
      tx_live = 1'b0;
    end
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Capacity writes happen only with the block idle; each one empties the ring.
  task automatic set_capacity(logic [QW-1:0] q);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= q;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Mostly well-formed requests sized to the current level, with a few
  // fully random ones (bad lengths, huge removes) mixed in.
  task automatic random_req(mix_e mode);
    int unsigned pick;
    int unsigned wcut;
    int unsigned lvl;
    int unsigned upper;
    int unsigned len;
    req_e        kind;
    logic [63:0] bytes;
    bytes = {$urandom, $urandom};
    lvl   = level_hint;
    pick  = $urandom_range(0, 99);
    if (pick < 6) begin
      kind = req_e'($urandom_range(0, 3));
      len  = $urandom_range(0, 2047);
    end else begin
      case (mode)
        MODE_FILL:  wcut = 70;
        MODE_DRAIN: wcut = 25;
        default:    wcut = 40;
      endcase
      pick = $urandom_range(0, 99);
      if (pick < wcut) kind = REQ_WRITE;
      else if (pick < wcut + (100 - wcut) * 45 / 100) kind = REQ_READ;
      else if (pick < wcut + (100 - wcut) * 75 / 100) kind = REQ_PEEK;
      else kind = REQ_REMOVE;
      case (kind)
        REQ_WRITE:  len = $urandom_range(0, 8);
        REQ_REMOVE: len = $urandom_range(0, 12);
        default: begin
          // short runs most of the time, full-length runs now and then
          upper = ($urandom_range(0, 3) == 0) ? MAX_RD : 8;
          if (upper > lvl) upper = lvl;
          len = (upper == 0) ? $urandom_range(0, 1) : $urandom_range(1, upper);
        end
      endcase
    end
    send_req(kind, bytes, len);
  endtask

  initial begin
    int            ph;
    logic [QW-1:0] q;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    burst_left = 3;

    // Directed part, reset capacity of 1024 bytes.
    send_req(REQ_WRITE, 64'd0, 0);                   // zero-length write
    send_req(REQ_READ, 64'd0, 0);                    // zero-length read, empty
    send_req(REQ_PEEK, 64'd0, 1);                    // short of data
    send_req(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 8);
    send_req(REQ_WRITE, 64'd0, 8);
    send_req(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 9); // write too long
    send_req(REQ_WRITE, 64'hFFFF_FFFF_FFFF_FFFF, 2047);
    send_req(REQ_PEEK, 64'd0, 16);
    send_req(REQ_READ, 64'd0, 65);                   // read too long
    send_req(REQ_READ, 64'd0, 3);
    send_req(REQ_REMOVE, 64'd0, 2);
    send_req(REQ_READ, 64'd0, 11);                   // drains to empty
    send_req(REQ_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 2047); // saturates at zero
    send_req(REQ_WRITE, 64'h0807_0605_0403_0201, 5);

    // Smallest ring: 4 bytes, full flag and no room.
    set_capacity(9'd1);
    send_req(REQ_WRITE, 64'h0807_0605_0403_0201, 4);
    send_req(REQ_WRITE, 64'h0000_0000_0000_00AA, 1);
    send_req(REQ_PEEK, 64'd0, 4);
    send_req(REQ_READ, 64'd0, 4);

    // Zero capacity acts as one quad.
    set_capacity(9'd0);
    send_req(REQ_WRITE, {$urandom, $urandom}, 5);
    send_req(REQ_WRITE, {$urandom, $urandom}, 4);
    send_req(REQ_REMOVE, 64'd0, 9);                  // saturates at the level

    // 12-byte ring: pointers wrap.
    set_capacity(9'd3);
    send_req(REQ_WRITE, {$urandom, $urandom}, 8);
    send_req(REQ_READ, 64'd0, 6);
    send_req(REQ_WRITE, {$urandom, $urandom}, 8);
    send_req(REQ_READ, 64'd0, 10);

    // Random phases over a spread of capacities, including the clamp at
    // 511 quads. Every third phase runs without idling.
    for (ph = 0; ph < 8; ph++) begin
      q = (ph == 5) ? QW'($urandom_range(1, 511)) : QW'(phase_caps[ph]);
      set_capacity(q);
      steady     = (ph % 3 == 2);
      burst_left = 1;
      for (int k = 0; k < 40; k++) begin
        random_req((k < 20) ? MODE_FILL : ((ph % 2 == 1) ? MODE_MIX : MODE_DRAIN));
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("PASS byte_ring_fifo_peek_discard");
    end else begin
      $display("FAIL byte_ring_fifo_peek_discard");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/brf_pkg.sv
src/brf_ram.sv
src/byte_ring_fifo_peek_discard.sv
dv/ring_fifo_checker.sv
dv/byte_ring_fifo_peek_discard_tb.sv
